FILE: sv/csvi_pkg.sv
// shared types and constants for the cel-shade vertex intensity block
// no dependencies; used by csvi_root_step and cel_shade_vertex_intensity_top
`default_nettype none

package csvi_pkg;

	localparam int NRM_W  = 16;
	localparam int CFG_W  = 48;
	localparam int PROD_W = 32;
	localparam int SUM_W  = 34;
	localparam int D_W    = 29;
	localparam int DL_W   = 45;
	localparam int DD_W   = 56;
	localparam int N_W    = 46;
	localparam int S_W    = 57;
	localparam int NH_W   = 22;
	localparam int NL_W   = 23;
	localparam int N2_W   = 90;
	localparam int QS_W   = 72;
	localparam int Q_W    = 15;

	localparam int FRONT_STAGES = 6;
	localparam int SRCH_STAGES  = Q_W;
	localparam int NUM_STAGES   = FRONT_STAGES + SRCH_STAGES;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COL2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_DIR   = 2'd3;

	localparam logic [CFG_W-1:0] RST_MATRIX_COL0 = 48'h0000_0000_1000;
	localparam logic [CFG_W-1:0] RST_MATRIX_COL1 = 48'h0000_1000_0000;
	localparam logic [CFG_W-1:0] RST_MATRIX_COL2 = 48'h1000_0000_0000;
	localparam logic [CFG_W-1:0] RST_LIGHT_DIR   = 48'h4000_0000_0000;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    last_vertex;
	} csvi_in_t;

	typedef struct packed {
		logic [Q_W-1:0] shade;
		logic           last_out;
	} csvi_out_t;

	// state carried through the shade search stages
	typedef struct packed {
		logic              last;
		logic              pos;
		logic [Q_W-1:0]    q;
		logic [N2_W-1:0]   p;
		logic [QS_W-1:0]   qs;
		logic [S_W-1:0]    s;
		logic [N2_W-1:0]   n2;
	} csvi_srch_t;

endpackage

`default_nettype wire

FILE: sv/csvi_root_step.sv
// one bit of the shade search: largest q with q*q*s <= n*n, one bit per stage
// depends on csvi_pkg
`default_nettype none

module csvi_root_step #(
	parameter int BIT = 0
) (
	input  wire                  clk,
	input  wire                  en,
	input  csvi_pkg::csvi_srch_t d,
	output csvi_pkg::csvi_srch_t q_o
);

	localparam int W  = csvi_pkg::N2_W;
	localparam int QW = csvi_pkg::QS_W;
	localparam int QB = csvi_pkg::Q_W;

	logic [W-1:0]  qs_term;
	logic [W-1:0]  s_term;
	logic [W-1:0]  cand;
	logic          take;
	csvi_pkg::csvi_srch_t nxt;

	// (q + 2^b)^2 s = q^2 s + 2^(b+1) q s + 2^(2b) s
	always_comb begin
		qs_term = W'(d.qs) << (BIT + 1);
		s_term  = W'(d.s) << (2 * BIT);
		cand    = d.p + qs_term + s_term;
		take    = d.pos && !d.q[QB-1] && (cand <= d.n2);
		nxt     = d;
		if (take) begin
			nxt.q  = d.q | (QB'(1) << BIT);
			nxt.p  = cand;
			nxt.qs = d.qs + (QW'(d.s) << BIT);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_o <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/cel_shade_vertex_intensity_top.sv
// top level: matrix rotate, dot and length terms, squared compare search for the shade
// depends on csvi_pkg and csvi_root_step
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_stall    csvi_in_t   (normal x,y,z, last_vertex)
//   out       output      out_valid/out_stall  csvi_out_t  (shade, last_out)
//   cfg       input       cfg_we               cfg_index, cfg_data (48 bits)
//
// one vertex per cycle while the output is not stalled; 6 arithmetic stages and 15 search stages
// the search resolves one shade bit per stage with a 90-bit add and compare
// reset clears the stage valid bits and loads the identity matrix and light along z
// each full stage holds while the one after it is full and held; a stall at the output
// backs up stage by stage, so bubbles are squeezed out and nothing is lost or repeated
`default_nettype none

module cel_shade_vertex_intensity_top (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  csvi_pkg::csvi_in_t                   in_data,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output csvi_pkg::csvi_out_t                  out_data,
	input  wire                                  cfg_we,
	input  wire [csvi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [csvi_pkg::CFG_W-1:0]            cfg_data
);

	localparam int NS = csvi_pkg::NUM_STAGES;
	localparam int NF = csvi_pkg::FRONT_STAGES;
	localparam int NQ = csvi_pkg::SRCH_STAGES;

	function automatic logic signed [csvi_pkg::NRM_W-1:0] lane(
		input logic [csvi_pkg::CFG_W-1:0] v,
		input int                         k
	);
		lane = $signed(v[csvi_pkg::NRM_W*k +: csvi_pkg::NRM_W]);
	endfunction

	// configuration
	logic [csvi_pkg::CFG_W-1:0] col0_q, col1_q, col2_q, light_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col0_q  <= csvi_pkg::RST_MATRIX_COL0;
			col1_q  <= csvi_pkg::RST_MATRIX_COL1;
			col2_q  <= csvi_pkg::RST_MATRIX_COL2;
			light_q <= csvi_pkg::RST_LIGHT_DIR;
		end else if (cfg_we) begin
			case (cfg_index)
				csvi_pkg::CFG_MATRIX_COL0: col0_q  <= cfg_data;
				csvi_pkg::CFG_MATRIX_COL1: col1_q  <= cfg_data;
				csvi_pkg::CFG_MATRIX_COL2: col2_q  <= cfg_data;
				csvi_pkg::CFG_LIGHT_DIR:   light_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// stage valid bits and load enables
	logic [NS:1]   stg_vld_q;
	logic [NS:1]   vld_nxt;
	logic [NS+1:1] ld;

	always_comb begin
		ld[NS+1] = !out_stall;
		for (int k = NS; k >= 1; k--) begin
			ld[k] = !stg_vld_q[k] || ld[k+1];
		end
		vld_nxt = {stg_vld_q[NS-1:1], in_valid};
	end

	assign in_stall  = !ld[1];
	assign out_valid = stg_vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (ld[k]) begin
					stg_vld_q[k] <= vld_nxt[k];
				end
			end
		end
	end

	// stage 1: matrix by normal products
	logic signed [csvi_pkg::PROD_W-1:0] prod_s1 [3][3];
	logic                               last_s1;

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k][0] <= lane(col0_q, k) * in_data.normal_x;
				prod_s1[k][1] <= lane(col1_q, k) * in_data.normal_y;
				prod_s1[k][2] <= lane(col2_q, k) * in_data.normal_z;
			end
			last_s1 <= in_data.last_vertex;
		end
	end

	// stage 2: rotated components, floor by 16
	logic signed [csvi_pkg::SUM_W-1:0] rsum [3];
	logic signed [csvi_pkg::D_W-1:0]   d_s2 [3];
	logic                              last_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rsum[k] = prod_s1[k][0] + prod_s1[k][1] + prod_s1[k][2];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			for (int k = 0; k < 3; k++) begin
				d_s2[k] <= csvi_pkg::D_W'(rsum[k] >>> 4);
			end
			last_s2 <= last_s1;
		end
	end

	// stage 3: light and self products
	logic signed [csvi_pkg::DL_W-1:0]  dl_s3 [3];
	logic        [csvi_pkg::DD_W-1:0]  dd_s3 [3];
	logic signed [2*csvi_pkg::D_W-1:0] sq    [3];
	logic                              last_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sq[k] = d_s2[k] * d_s2[k];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			for (int k = 0; k < 3; k++) begin
				dl_s3[k] <= d_s2[k] * lane(light_q, k);
				dd_s3[k] <= sq[k][csvi_pkg::DD_W-1:0];
			end
			last_s3 <= last_s2;
		end
	end

	// stage 4: dot product and squared length
	logic signed [csvi_pkg::N_W-1:0] n_s4;
	logic        [csvi_pkg::S_W-1:0] s_s4;
	logic                            last_s4;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			n_s4    <= dl_s3[0] + dl_s3[1] + dl_s3[2];
			s_s4    <= dd_s3[0] + dd_s3[1] + dd_s3[2];
			last_s4 <= last_s3;
		end
	end

	// stage 5: partial products of n squared
	logic [csvi_pkg::N_W-2:0]         n_abs;
	logic [csvi_pkg::NH_W-1:0]        nh;
	logic [csvi_pkg::NL_W-1:0]        nl;
	logic [2*csvi_pkg::NH_W-1:0]      hh_s5;
	logic [csvi_pkg::NH_W+csvi_pkg::NL_W-1:0] hl_s5;
	logic [2*csvi_pkg::NL_W-1:0]      ll_s5;
	logic [csvi_pkg::S_W-1:0]         s_s5;
	logic                             pos_s5;
	logic                             last_s5;

	always_comb begin
		n_abs = n_s4[csvi_pkg::N_W-2:0];
		nh    = n_abs[csvi_pkg::N_W-2:csvi_pkg::NL_W];
		nl    = n_abs[csvi_pkg::NL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			hh_s5   <= nh * nh;
			hl_s5   <= nh * nl;
			ll_s5   <= nl * nl;
			s_s5    <= s_s4;
			pos_s5  <= (s_s4 != '0) && !n_s4[csvi_pkg::N_W-1] && (n_s4 != '0);
			last_s5 <= last_s4;
		end
	end

	// stage 6: n squared
	localparam int W2 = csvi_pkg::N2_W;
	csvi_pkg::csvi_srch_t srch_s6;
	logic [W2-1:0]        n2_sum;

	always_comb begin
		n2_sum = (W2'(hh_s5) << (2 * csvi_pkg::NL_W))
		       + (W2'(hl_s5) << (csvi_pkg::NL_W + 1))
		       + W2'(ll_s5);
	end

	always_ff @(posedge clk) begin
		if (ld[6]) begin
			srch_s6.last <= last_s5;
			srch_s6.pos  <= pos_s5;
			srch_s6.q    <= '0;
			srch_s6.p    <= '0;
			srch_s6.qs   <= '0;
			srch_s6.s    <= s_s5;
			srch_s6.n2   <= n2_sum;
		end
	end

	// stages 7 onward: shade search, saturation bit first
	csvi_pkg::csvi_srch_t srch [NQ+1];

	assign srch[0] = srch_s6;

	for (genvar i = 0; i < NQ; i++) begin : g_step
		csvi_root_step #(
			.BIT(NQ - 1 - i)
		) u_step (
			.clk (clk),
			.en  (ld[NF+1+i]),
			.d   (srch[i]),
			.q_o (srch[i+1])
		);
	end

	assign out_data.shade    = srch[NQ].q;
	assign out_data.last_out = srch[NQ].last;

endmodule

`default_nettype wire
